// ===== src/pcrl_pkg.sv =====
// Package for the per-client rate limiter: widths, codes and table geometry.
// No dependencies; used by per_client_rate_limiter (pcrl_ram does not use it).
package pcrl_pkg;
    localparam int TableEntries = 64;
    localparam int IdxW = $clog2(TableEntries);
    localparam int CntW = IdxW + 1;
    localparam int EntryW = 32 + 16 + 32;
    localparam logic [31:0] WindowMs = 32'd2000;
    localparam logic [31:0] IdleMs = 32'd61000;
    localparam logic [15:0] CountMax = 16'hFFFF;
    localparam logic [23:0] TotalMax = 24'hFFFFFF;

    localparam logic [1:0] ReqClient = 2'd0;
    localparam logic [1:0] ReqClear = 2'd1;
    localparam logic [1:0] ReqEvict = 2'd2;

    localparam logic [0:0] CfgLimit = 1'd0;
    localparam logic [0:0] CfgThresh = 1'd1;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] count;
        logic [31:0] stamp;
    } t_entry;

    function automatic logic [23:0] sat_add(input logic [23:0] a, input logic [15:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {9'd0, b};
        return s[24] ? TotalMax : s[23:0];
    endfunction
endpackage

// ===== src/pcrl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module pcrl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== src/per_client_rate_limiter.sv =====
// Top level of the per-client rate limiter: table walk sequencer.
// Depends on pcrl_pkg and pcrl_ram (entry memory).
//
// channel   direction  ports                                        transfer
// command   in         start, i_req_type, i_client_addr, i_now_ms   start && !busy
// result    out        o_done, o_blocked, o_attack_mode, o_table_full  o_done
// config    in         i_cfg_we, i_cfg_idx, i_cfg_data               i_cfg_we
//
// A request walks the table twice through the entry memory read port, one entry
// a cycle: once to find the client or a free entry, once after the update to
// rebuild the saturated total. Busy holds until the walks are done and falls as
// the result strobe rises. A full table skips the second walk, an evict walks
// once; a request in attack mode, a clear and a no-op go straight to the result.
// Reset clears valid flags (flip-flops), total and attack flag at once. The
// receiver cannot stall; each result strobe lasts one cycle.
module per_client_rate_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_client_addr,
    input  logic [31:0] i_now_ms,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    output logic        o_done,
    output logic        o_blocked,
    output logic        o_attack_mode,
    output logic        o_table_full
);
    localparam int N = pcrl_pkg::TableEntries;
    localparam int IW = pcrl_pkg::IdxW;
    localparam int CW = pcrl_pkg::CntW;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_UPD, S_SUM, S_FIN} t_state;

    t_state               r_state;
    logic [1:0]           r_type;
    logic [31:0]          r_addr, r_now;
    logic [15:0]          r_limit;
    logic [23:0]          r_thresh, r_total, r_sum;
    logic                 r_attack;
    logic [N-1:0]         r_valid;
    logic [CW-1:0]        r_rd;     // next read index
    logic [CW-1:0]        r_chk;    // index whose data is on the read port
    logic                 r_chk_v;
    logic                 r_hit, r_free_f;
    logic [IW-1:0]        r_hit_i, r_free_i;
    logic [15:0]          r_newc;

    logic                 we;
    logic [IW-1:0]        waddr, raddr;
    pcrl_pkg::t_entry     wdata, rd;
    logic [pcrl_pkg::EntryW-1:0] rd_bits;

    assign rd = pcrl_pkg::t_entry'(rd_bits);
    assign raddr = r_rd[IW-1:0];
    assign busy = (r_state != S_IDLE);

    pcrl_ram #(.Width(pcrl_pkg::EntryW), .Depth(N)) u_tab (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd_bits)
    );

    logic [IW-1:0] ci;
    logic          cv;
    logic [31:0]   age;
    assign ci = r_chk[IW-1:0];
    assign cv = r_chk_v && r_valid[ci];
    assign age = r_now - rd.stamp;

    // write port: single update of the hit/new entry; a new client starts at one
    always_comb begin
        we = (r_state == S_UPD) && (r_hit || r_free_f);
        waddr = r_hit ? r_hit_i : r_free_i;
        wdata.addr = r_addr;
        wdata.count = r_hit ? r_newc : 16'd1;
        wdata.stamp = r_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= 16'd100;
            r_thresh <= 24'd1000;
            r_total <= '0;
            r_attack <= 1'b0;
            r_valid <= '0;
            o_done <= 1'b0;
            r_chk_v <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pcrl_pkg::CfgLimit:  r_limit <= i_cfg_data[15:0];
                    pcrl_pkg::CfgThresh: r_thresh <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_type <= i_req_type;
                        r_addr <= i_client_addr;
                        r_now <= i_now_ms;
                        r_rd <= '0;
                        r_chk_v <= 1'b0;
                        r_hit <= 1'b0;
                        r_free_f <= 1'b0;
                        r_sum <= '0;
                        o_blocked <= 1'b0;
                        o_table_full <= 1'b0;
                        if (i_req_type == pcrl_pkg::ReqClient && r_attack) begin
                            o_blocked <= 1'b1;
                            r_state <= S_FIN;
                        end else if (i_req_type == pcrl_pkg::ReqClear) begin
                            r_attack <= 1'b0;
                            r_valid <= '0;
                            r_total <= '0;
                            r_state <= S_FIN;
                        end else if (i_req_type == pcrl_pkg::ReqClient
                                     || i_req_type == pcrl_pkg::ReqEvict) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    // advance read pointer, examine the entry read last cycle
                    r_chk <= r_rd;
                    r_chk_v <= (r_rd < CW'(N));
                    if (r_rd < CW'(N)) r_rd <= r_rd + CW'(1);
                    if (r_chk_v) begin
                        if (r_type == pcrl_pkg::ReqEvict) begin
                            if (cv && age >= pcrl_pkg::IdleMs) r_valid[ci] <= 1'b0;
                            else if (cv) r_sum <= pcrl_pkg::sat_add(r_sum, rd.count);
                        end else if (!r_hit) begin
                            if (cv && rd.addr == r_addr) begin
                                logic [15:0] base;
                                r_hit <= 1'b1;
                                r_hit_i <= ci;
                                base = (age >= pcrl_pkg::WindowMs) ? 16'd0 : rd.count;
                                r_newc <= (base == pcrl_pkg::CountMax) ? base : base + 16'd1;
                            end else if (!cv && !r_free_f) begin
                                r_free_f <= 1'b1;
                                r_free_i <= ci;
                            end
                        end
                    end
                    if (r_chk_v && r_chk == CW'(N-1)) begin
                        if (r_type == pcrl_pkg::ReqEvict) begin
                            r_total <= (cv && age < pcrl_pkg::IdleMs)
                                ? pcrl_pkg::sat_add(r_sum, rd.count) : r_sum;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_UPD;
                        end
                    end
                end
                S_UPD: begin
                    if (!r_hit && !r_free_f) begin
                        o_table_full <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        if (!r_hit) begin
                            r_valid[r_free_i] <= 1'b1;
                            r_newc <= 16'd1;
                        end
                        r_rd <= '0;
                        r_chk_v <= 1'b0;
                        r_sum <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // re-walk for the saturated total; the write is already visible
                    r_chk <= r_rd;
                    r_chk_v <= (r_rd < CW'(N));
                    if (r_rd < CW'(N)) r_rd <= r_rd + CW'(1);
                    if (cv) r_sum <= pcrl_pkg::sat_add(r_sum, rd.count);
                    if (r_chk_v && r_chk == CW'(N-1)) begin
                        logic [23:0] tot;
                        tot = cv ? pcrl_pkg::sat_add(r_sum, rd.count) : r_sum;
                        r_total <= tot;
                        if (r_newc > r_limit && tot > r_thresh) begin
                            r_attack <= 1'b1;
                            o_blocked <= 1'b1;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_done <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_attack_mode = r_attack;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE) else $error("result outside idle");
    a_block_attack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_blocked |-> r_attack) else $error("blocked without attack");
    a_full_noblk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_blocked && o_table_full)) else $error("blocked and full");
endmodule
